@@ design/hpt_pkg.sv @@
// Shared types and constants for the homogeneous point transform.
// Holds the request and result payload structs, mode codes and a clamp helper.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package hpt_pkg;

	localparam int CoefWidthDef = 32;
	localparam int CoefWidthMax = 48;
	localparam int FracBits     = 16;
	localparam int CoordWidth   = 32;
	localparam int NumRows      = 4;
	localparam int NumCoords    = 3;

	localparam logic MODE_LOAD  = 1'b0;
	localparam logic MODE_XFORM = 1'b1;

	typedef struct packed {
		logic                          mode;
		logic [3:0]                    coef_index;
		logic signed [CoordWidth-1:0]  coef_value;
		logic signed [CoordWidth-1:0]  point_x;
		logic signed [CoordWidth-1:0]  point_y;
		logic signed [CoordWidth-1:0]  point_z;
	} in_req_t;

	typedef struct packed {
		logic signed [CoordWidth-1:0]  out_x;
		logic signed [CoordWidth-1:0]  out_y;
		logic signed [CoordWidth-1:0]  out_z;
		logic                          divisor_zero;
		logic                          saturated;
	} out_rsp_t;

	// What one divider lane hands to the merging stage.
	typedef struct packed {
		logic signed [CoordWidth-1:0]  quot;
		logic                          sat;
		logic                          dz;
	} div_rsp_t;

	// Clamps a value to the signed range of a cw-bit coefficient.
	function automatic logic signed [CoefWidthMax:0] clamp_cw(
		input logic signed [CoefWidthMax:0] v,
		input int unsigned                  cw
	);
		logic signed [CoefWidthMax:0] mx;
		logic signed [CoefWidthMax:0] mn;
		mx = ((CoefWidthMax+1)'(1) <<< (cw - 1)) - (CoefWidthMax+1)'(1);
		mn = -mx - (CoefWidthMax+1)'(1);
		if (v > mx) begin
			return mx;
		end else if (v < mn) begin
			return mn;
		end
		return v;
	endfunction

endpackage
`default_nettype wire

@@ design/hpt_row_lane.sv @@
// One matrix row: three coordinate products plus the offset term, in three stages.
// Uses hpt_pkg. Each coefficient is split so that no multiplier exceeds ~32x33 bits.
`timescale 1ns / 1ps
`default_nettype none
module hpt_row_lane #(
	parameter int CW = hpt_pkg::CoefWidthDef
) (
	input  wire logic                                     clk,
	input  wire logic                                     en,
	input  wire logic [hpt_pkg::NumCoords-1:0][hpt_pkg::CoordWidth-1:0] pt,
	input  wire logic [hpt_pkg::NumRows-1:0][CW-1:0]      coef,
	output logic signed [CW+33:0]                         row_sum
);
	localparam int PW  = hpt_pkg::CoordWidth;
	localparam int HW  = CW - 15;          // high part of a coefficient
	localparam int PLW = PW + 16;          // point times low part
	localparam int PHW = PW + HW;          // point times high part
	localparam int PRW = PW + CW;          // full product
	localparam int SW  = CW + 34;          // row sum

	logic signed [PLW-1:0] pl_s1 [hpt_pkg::NumCoords];
	logic signed [PHW-1:0] ph_s1 [hpt_pkg::NumCoords];
	logic signed [CW-1:0]  off_s1;
	logic signed [PRW-1:0] prod_s2 [hpt_pkg::NumCoords];
	logic signed [CW-1:0]  off_s2;
	logic signed [SW-1:0]  sum_s3;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < hpt_pkg::NumCoords; k++) begin
				pl_s1[k] <= $signed(pt[k]) * $signed({1'b0, coef[k][14:0]});
				ph_s1[k] <= $signed(pt[k]) * $signed(coef[k][CW-1:15]);
				prod_s2[k] <= (PRW'(ph_s1[k]) <<< 15) + PRW'(pl_s1[k]);
			end
			off_s1 <= $signed(coef[3]);
			off_s2 <= off_s1;
			sum_s3 <= SW'(prod_s2[0]) + SW'(prod_s2[1]) + SW'(prod_s2[2])
				+ (SW'(off_s2) <<< hpt_pkg::FracBits);
		end
	end

	assign row_sum = sum_s3;

endmodule
`default_nettype wire

@@ design/hpt_div_lane.sv @@
// One coordinate divider: (num * 2^16) / den, truncated, saturated to 32 bits.
// Uses hpt_pkg. Restoring division, one quotient bit per pipeline stage.
`timescale 1ns / 1ps
`default_nettype none
module hpt_div_lane #(
	parameter int SW = hpt_pkg::CoefWidthDef + 34
) (
	input  wire logic                  clk,
	input  wire logic                  en,
	input  wire logic signed [SW-1:0]  num,
	input  wire logic signed [SW-1:0]  den,
	output hpt_pkg::div_rsp_t          rsp
);
	localparam int NW = SW + hpt_pkg::FracBits;
	localparam int RW = SW + 32;
	localparam int QW = hpt_pkg::CoordWidth;

	logic signed [NW-1:0] num_sh;
	logic [NW-1:0]        nmag_s0;
	logic [SW-1:0]        dmag_s0;
	logic                 neg_s0;
	logic                 dz_s0;

	// Index g holds the state before quotient bit 31-g is decided.
	logic [RW-1:0] rem_st  [QW+1];
	logic [QW-1:0] quot_st [QW+1];
	logic [SW-1:0] dmag_st [QW+1];
	logic          neg_st  [QW+1];
	logic          ovf_st  [QW+1];
	logic          dz_st   [QW+1];

	logic [QW:0]          lim;
	logic                 sat_c;
	logic [QW-1:0]        mag_c;
	hpt_pkg::div_rsp_t    rsp_q;

	assign num_sh = NW'(num) <<< hpt_pkg::FracBits;

	always_ff @(posedge clk) begin
		if (en) begin
			nmag_s0 <= num_sh[NW-1] ? NW'(-num_sh) : NW'(num_sh);
			dmag_s0 <= den[SW-1] ? SW'(-den) : SW'(den);
			neg_s0  <= num[SW-1] ^ den[SW-1];
			dz_s0   <= (den == '0);

			// A quotient of 2^32 or more can only saturate.
			rem_st[0]  <= RW'(nmag_s0);
			quot_st[0] <= '0;
			dmag_st[0] <= dmag_s0;
			neg_st[0]  <= neg_s0;
			dz_st[0]   <= dz_s0;
			ovf_st[0]  <= RW'(nmag_s0) >= (RW'(dmag_s0) << QW);

			for (int g = 0; g < QW; g++) begin
				if (rem_st[g] >= (RW'(dmag_st[g]) << (QW - 1 - g))) begin
					rem_st[g+1]  <= rem_st[g] - (RW'(dmag_st[g]) << (QW - 1 - g));
					quot_st[g+1] <= quot_st[g] | (QW'(1) << (QW - 1 - g));
				end else begin
					rem_st[g+1]  <= rem_st[g];
					quot_st[g+1] <= quot_st[g];
				end
				dmag_st[g+1] <= dmag_st[g];
				neg_st[g+1]  <= neg_st[g];
				ovf_st[g+1]  <= ovf_st[g];
				dz_st[g+1]   <= dz_st[g];
			end

			rsp_q.quot <= dz_st[QW] ? '0 : (neg_st[QW] ? QW'(-mag_c) : mag_c);
			rsp_q.sat  <= sat_c && !dz_st[QW];
			rsp_q.dz   <= dz_st[QW];
		end
	end

	always_comb begin
		lim   = neg_st[QW] ? (QW+1)'(33'h0_8000_0000) : (QW+1)'(33'h0_7FFF_FFFF);
		sat_c = ovf_st[QW] || ({1'b0, quot_st[QW]} > lim);
		mag_c = sat_c ? lim[QW-1:0] : quot_st[QW];
	end

	assign rsp = rsp_q;

endmodule
`default_nettype wire

@@ design/homogeneous_point_transform.sv @@
// Homogeneous 4x4 point transform with perspective divide, top level.
// Holds the matrix, four row lanes, three divider lanes and the merge stage.
// Depends on hpt_pkg, hpt_row_lane and hpt_div_lane.
//
// Usage: requests arrive on in_valid/in_ready/in_data. A load request
// (mode 0) writes one Q16.16 coefficient at row*4+column and produces no
// result. A transform request (mode 1) produces one result on
// out_valid/out_ready/out_data with the divided x, y, z and two flags.
// From acceptance to out_valid a request passes the row lanes (partial
// products, product assembly, row sum), then the divider lanes (operand
// magnitudes, range check, 32 restoring steps with one quotient bit per
// stage, sign and saturation), then the output register. Throughput is
// one request per cycle while the pipeline is not held.
// Reset loads the identity matrix and empties the pipeline.
// When the receiver stalls, the result waits in the output register and
// requests keep flowing until a finished result reaches the pipeline end;
// then the whole pipeline and in_ready hold until the result is taken.
`timescale 1ns / 1ps
`default_nettype none
module homogeneous_point_transform #(
	parameter int COEF_WIDTH = hpt_pkg::CoefWidthDef
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire hpt_pkg::in_req_t  in_data,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output hpt_pkg::out_rsp_t      out_data
);
	localparam int CW   = COEF_WIDTH;
	localparam int SW   = CW + 34;
	localparam int VLEN = 3 + 3 + hpt_pkg::CoordWidth;
	localparam int NR   = hpt_pkg::NumRows;
	localparam int NC   = hpt_pkg::NumCoords;

	logic [CW-1:0]        matrix_q [NR*NR];
	logic [VLEN-1:0]      vld_q;
	logic                 en;
	logic                 load_acc;
	logic [CW-1:0]        coef_sat;
	logic [CW-1:0]        coef_one;
	logic [NC-1:0][hpt_pkg::CoordWidth-1:0] pt;
	logic signed [SW-1:0] row_sum [NR];
	hpt_pkg::div_rsp_t    div_rsp [NC];
	logic                 out_valid_q;
	hpt_pkg::out_rsp_t    out_data_q;

	// The pipeline holds only while a finished result is blocked at both ends.
	assign en       = !(out_valid_q && !out_ready && vld_q[VLEN-1]);
	assign in_ready = en;
	assign load_acc = in_valid && in_ready && (in_data.mode == hpt_pkg::MODE_LOAD);

	assign coef_sat = CW'(hpt_pkg::clamp_cw(
		(hpt_pkg::CoefWidthMax+1)'(in_data.coef_value), CW));
	assign coef_one = CW'(hpt_pkg::clamp_cw(
		(hpt_pkg::CoefWidthMax+1)'(65536), CW));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NR*NR; i++) begin
				matrix_q[i] <= (i == 0 || i == 5 || i == 10 || i == 15) ? coef_one : '0;
			end
		end else if (load_acc) begin
			matrix_q[in_data.coef_index] <= coef_sat;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[VLEN-2:0],
				in_valid && (in_data.mode == hpt_pkg::MODE_XFORM)};
		end
	end

	assign pt[0] = in_data.point_x;
	assign pt[1] = in_data.point_y;
	assign pt[2] = in_data.point_z;

	for (genvar r = 0; r < NR; r++) begin : g_row
		logic [NR-1:0][CW-1:0] coef_row;
		for (genvar c = 0; c < NR; c++) begin : g_col
			assign coef_row[c] = matrix_q[r*NR + c];
		end
		hpt_row_lane #(.CW(CW)) u_row (
			.clk     (clk),
			.en      (en),
			.pt      (pt),
			.coef    (coef_row),
			.row_sum (row_sum[r])
		);
	end

	for (genvar d = 0; d < NC; d++) begin : g_div
		hpt_div_lane #(.SW(SW)) u_div (
			.clk (clk),
			.en  (en),
			.num (row_sum[d]),
			.den (row_sum[NR-1]),
			.rsp (div_rsp[d])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en && vld_q[VLEN-1]) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (en && vld_q[VLEN-1]) begin
			out_data_q.out_x        <= div_rsp[0].quot;
			out_data_q.out_y        <= div_rsp[1].quot;
			out_data_q.out_z        <= div_rsp[2].quot;
			out_data_q.divisor_zero <= div_rsp[0].dz;
			out_data_q.saturated    <= div_rsp[0].sat || div_rsp[1].sat || div_rsp[2].sat;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	a_dz_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_data.divisor_zero) |->
		(out_data.out_x == '0 && out_data.out_y == '0 && out_data.out_z == '0
		&& !out_data.saturated))
		else $error("zero divisor result is not all zero");

	a_sat_limit: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_data.saturated) |->
		(out_data.out_x == 32'sh7FFF_FFFF || out_data.out_x == 32'sh8000_0000
		|| out_data.out_y == 32'sh7FFF_FFFF || out_data.out_y == 32'sh8000_0000
		|| out_data.out_z == 32'sh7FFF_FFFF || out_data.out_z == 32'sh8000_0000))
		else $error("saturated flag without a clipped coordinate");

	a_load_write: assert property (@(posedge clk) disable iff (!arst_n)
		load_acc |=> (matrix_q[$past(in_data.coef_index)] == $past(coef_sat)))
		else $error("coefficient load not stored");

endmodule
`default_nettype wire
